// ===== hw/rtl/rhc_pkg.sv =====
package rhc_pkg;

  // Channel resolution; the quotient and numerator widths below follow from it.
  localparam int ChannelBits = 10;

  // Result field widths.
  localparam int HueW = 9;
  localparam int SatW = 7;
  localparam int BriW = 9;

  // Scale factors and hue sector bases.
  localparam int HueScale     = 60;
  localparam int SatScale     = 100;
  localparam int BriScale     = 100;
  localparam int BriFullScale = 255;
  localparam int HueGreenBase = 120;
  localparam int HueBlueBase  = 240;
  localparam int HueWrap      = 360;

  // Largest quotient any lane produces sets the number of divider cells.
  localparam int BriQuoMax = ((1 << ChannelBits) - 1) * BriScale / BriFullScale;
  localparam int QuoW      = $clog2(BriQuoMax + 1);
  localparam int NumW      = ChannelBits + QuoW;

  // Divider lanes.
  localparam int LaneHue = 0;
  localparam int LaneSat = 1;
  localparam int LaneBri = 2;
  localparam int LaneCnt = 3;

  typedef logic [ChannelBits-1:0] chan_t;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // One restoring-division lane: partial remainder, numerator bits that
  // shift out on the left while quotient bits shift in on the right.
  typedef struct packed {
    chan_t            dvs;
    chan_t            rem;
    logic [QuoW-1:0]  quo;
  } lane_t;

  // Item payload as it travels down the cell chain.
  typedef struct packed {
    logic                   gray;
    logic                   neg;
    sector_e                sector;
    lane_t [LaneCnt-1:0]    lane;
  } cell_t;

endpackage

// ===== hw/rtl/rhc_pix_if.sv =====
interface rhc_pix_if;
  import rhc_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ===== hw/rtl/rhc_hsv_if.sv =====
interface rhc_hsv_if;
  import rhc_pkg::*;

  logic            valid;
  logic            ready;
  logic [HueW-1:0] hue;
  logic [SatW-1:0] saturation;
  logic [BriW-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);

endinterface

// ===== hw/rtl/rhc_front.sv =====
module rhc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  rhc_pix_if.sink        pix_i,
  output logic           vld_o,
  output rhc_pkg::cell_t cell_o
);
  import rhc_pkg::*;

  // Stage A: pick the largest channel, the smallest one and the hue pair.
  sector_e sector_d, sector_q;
  chan_t   mx_d, mx_q;
  chan_t   mn_d, mn_q;
  chan_t   pa, pb;
  chan_t   mag_d, mag_q;
  logic    neg_d, neg_q;
  logic    a_vld_q;

  // Stage B: scale numerators and load the divider lanes.
  chan_t           dlt;
  logic [NumW-1:0] num_hue, num_sat, num_bri;
  cell_t           cell_d, cell_q;
  logic            b_vld_q;

  assign pix_i.ready = en_i;

  always_comb begin
    // Ties go to red first, then green.
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      sector_d = SecRed;
    end else if (pix_i.green >= pix_i.blue) begin
      sector_d = SecGreen;
    end else begin
      sector_d = SecBlue;
    end

    mn_d = (pix_i.red <= pix_i.green) ? pix_i.red : pix_i.green;
    if (pix_i.blue < mn_d) begin
      mn_d = pix_i.blue;
    end

    case (sector_d)
      SecRed: begin
        mx_d = pix_i.red;
        pa   = pix_i.green;
        pb   = pix_i.blue;
      end
      SecGreen: begin
        mx_d = pix_i.green;
        pa   = pix_i.blue;
        pb   = pix_i.red;
      end
      default: begin
        mx_d = pix_i.blue;
        pa   = pix_i.red;
        pb   = pix_i.green;
      end
    endcase

    neg_d = (pa < pb);
    mag_d = neg_d ? (pb - pa) : (pa - pb);
  end

  always_comb begin
    dlt     = mx_q - mn_q;
    num_hue = NumW'(mag_q) * NumW'(HueScale);
    num_sat = NumW'(dlt) * NumW'(SatScale);
    num_bri = NumW'(mx_q) * NumW'(BriScale);

    cell_d.gray   = (dlt == '0);
    cell_d.neg    = neg_q;
    cell_d.sector = sector_q;

    cell_d.lane[LaneHue].dvs = dlt;
    cell_d.lane[LaneHue].rem = ChannelBits'(num_hue >> QuoW);
    cell_d.lane[LaneHue].quo = num_hue[QuoW-1:0];

    cell_d.lane[LaneSat].dvs = mx_q;
    cell_d.lane[LaneSat].rem = ChannelBits'(num_sat >> QuoW);
    cell_d.lane[LaneSat].quo = num_sat[QuoW-1:0];

    cell_d.lane[LaneBri].dvs = ChannelBits'(BriFullScale);
    cell_d.lane[LaneBri].rem = ChannelBits'(num_bri >> QuoW);
    cell_d.lane[LaneBri].quo = num_bri[QuoW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= pix_i.valid;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_q <= sector_d;
      mx_q     <= mx_d;
      mn_q     <= mn_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      cell_q   <= cell_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/rhc_div_cell.sv =====
module rhc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  rhc_pkg::cell_t cell_i,
  output logic           vld_o,
  output rhc_pkg::cell_t cell_o
);
  import rhc_pkg::*;

  logic [LaneCnt-1:0][ChannelBits:0] trial;
  logic [LaneCnt-1:0]                fits;
  cell_t                             cell_d, cell_q;
  logic                              vld_q;

  // One restoring step per lane: shift in the next numerator bit, subtract
  // the divisor where it fits, shift the quotient bit in.
  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < LaneCnt; l++) begin
      trial[l] = {cell_i.lane[l].rem, cell_i.lane[l].quo[QuoW-1]};
      fits[l]  = (trial[l] >= {1'b0, cell_i.lane[l].dvs});
      cell_d.lane[l].rem = fits[l] ? ChannelBits'(trial[l] - {1'b0, cell_i.lane[l].dvs})
                                   : trial[l][ChannelBits-1:0];
      cell_d.lane[l].quo = {cell_i.lane[l].quo[QuoW-2:0], fits[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/rhc_back.sv =====
module rhc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  rhc_pkg::cell_t cell_i,
  output logic           en_o,
  rhc_hsv_if.source      hsv_o
);
  import rhc_pkg::*;

  logic [HueW:0]   q_hue, base, hue_sum;
  logic [HueW-1:0] hue_new;
  logic [SatW-1:0] sat_new;
  logic [BriW-1:0] bri_new;

  logic            out_vld_d, out_vld_q;
  logic            skid_vld_d, skid_vld_q;
  logic            load_out, load_skid, move_skid;
  logic [HueW-1:0] out_hue_q, skid_hue_q;
  logic [SatW-1:0] out_sat_q, skid_sat_q;
  logic [BriW-1:0] out_bri_q, skid_bri_q;

  // Finish the hue: add the sector base, wrap a negative red hue, force hue 0 for gray.
  always_comb begin
    q_hue = (HueW + 1)'(cell_i.lane[LaneHue].quo);
    case (cell_i.sector)
      SecGreen: base = (HueW + 1)'(HueGreenBase);
      SecBlue:  base = (HueW + 1)'(HueBlueBase);
      default:  base = '0;
    endcase

    if (cell_i.gray) begin
      hue_sum = '0;
    end else if (!cell_i.neg) begin
      hue_sum = base + q_hue;
    end else if (base >= q_hue) begin
      hue_sum = base - q_hue;
    end else begin
      hue_sum = base + (HueW + 1)'(HueWrap) - q_hue;
    end

    hue_new = HueW'(hue_sum);
    sat_new = cell_i.gray ? '0 : SatW'(cell_i.lane[LaneSat].quo);
    bri_new = BriW'(cell_i.lane[LaneBri].quo);
  end

  // Output register plus skid slot; the chain advances while the skid is empty.
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    move_skid  = 1'b0;
    if (skid_vld_q) begin
      if (hsv_o.ready) begin
        move_skid  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (vld_i) begin
      if (!out_vld_q || hsv_o.ready) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (hsv_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hue_q <= hue_new;
      out_sat_q <= sat_new;
      out_bri_q <= bri_new;
    end else if (move_skid) begin
      out_hue_q <= skid_hue_q;
      out_sat_q <= skid_sat_q;
      out_bri_q <= skid_bri_q;
    end
    if (load_skid) begin
      skid_hue_q <= hue_new;
      skid_sat_q <= sat_new;
      skid_bri_q <= bri_new;
    end
  end

  assign en_o             = !skid_vld_q;
  assign hsv_o.valid      = out_vld_q;
  assign hsv_o.hue        = out_hue_q;
  assign hsv_o.saturation = out_sat_q;
  assign hsv_o.brightness = out_bri_q;

endmodule

// ===== hw/rtl/rgb_to_hsv_converter_top.sv =====
// RGB to HSV converter. Takes one red, green, blue sample per item on pix_i and returns
// hue in whole degrees (0..359), saturation in percent (0..100) and brightness as
// 100 * max / 255 (not saturated) on hsv_o, one result item per input item, in order.
// Gray and black samples give hue 0 and saturation 0. The block accepts one item every
// clock cycle while its output skid slot is empty; an accepted item passes two front
// stages, one divider cell per quotient bit and the output register on its way to hsv_o.
// The divider is a chain of identical cells, each doing one restoring-division step for
// the hue, saturation and brightness lanes at once, so the quotient width of the brightness
// lane sets the chain length. A skid slot behind the output register keeps pix_i.ready
// registered; an item reaching a stalled, full output register goes to the skid slot,
// then pix_i.ready drops and the chain holds. Reset is asynchronous and active low.
module rgb_to_hsv_converter_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);
  import rhc_pkg::*;

  // Chain advance: high while the output skid slot is empty.
  logic                en;

  // Item payload and valid at each link of the chain; link 0 leaves the front stages.
  cell_t               link_cell [QuoW+1];
  logic [QuoW:0]       link_vld;

  // Find max, min and the hue pair, then scale the three numerators.
  rhc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .pix_i  (pix_i),
    .vld_o  (link_vld[0]),
    .cell_o (link_cell[0])
  );

  // One quotient bit per cell, most significant first.
  for (genvar c = 0; c < QuoW; c++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (link_vld[c]),
      .cell_i (link_cell[c]),
      .vld_o  (link_vld[c+1]),
      .cell_o (link_cell[c+1])
    );
  end

  // Fold in the hue sector, clear gray results, register and hand off.
  rhc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (link_vld[QuoW]),
    .cell_i (link_cell[QuoW]),
    .en_o   (en),
    .hsv_o  (hsv_o)
  );

`ifndef SYNTHESIS
  // Hue wraps below a full turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue < HueW'(HueWrap)))
    else $error("hue out of range");

  // Saturation never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.saturation <= SatW'(SatScale)))
    else $error("saturation out of range");

  // The chain only holds when a result already waits in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> hsv_o.valid)
    else $error("input stalled with empty output");

  // A stall with a result in the chain's last cell leaves that cell loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && link_vld[QuoW]) |=> link_vld[QuoW])
    else $error("held item lost at end of chain");
`endif

endmodule
